FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bca_pkg.sv
package bca_pkg;

    localparam int unsigned CHROM_W     = 16;
    localparam int unsigned POS_W       = 31;
    localparam int unsigned DEPTH_W     = 16;
    localparam int unsigned SPAN_W      = 16;
    localparam int unsigned START_W     = 32;
    localparam int unsigned VALUE_W     = 40;
    localparam int unsigned SUM_W       = 32;
    localparam int unsigned BSIZE_W     = 16;
    localparam int unsigned RATIO_W     = 24;
    localparam int unsigned NUM_W       = 56;
    localparam int unsigned DEN_W       = 24;
    localparam int unsigned IN_TDATA_W  = 96;
    localparam int unsigned OUT_TDATA_W = 104;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 31;

    localparam int unsigned DIV_CNT_W        = 6;
    localparam int unsigned DIV_WIDE_STEPS   = 56;
    localparam int unsigned DIV_NARROW_STEPS = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_RATIO  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BEGIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 8'd3;

    localparam logic [BSIZE_W-1:0] BIN_SIZE_RST    = 16'd50;
    localparam logic [RATIO_W-1:0] NORM_RATIO_RST  = 24'd65536;
    localparam logic [POS_W-1:0]   RANGE_BEGIN_RST = 31'd0;
    localparam logic [POS_W-1:0]   RANGE_END_RST   = 31'h7fffffff;

    localparam logic KIND_HDR = 1'b0;
    localparam logic KIND_VAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_POS,
        ST_DIV_LEN,
        ST_BIN,
        ST_HDR,
        ST_MUL_NUM,
        ST_MUL_START,
        ST_DIV_VAL,
        ST_VAL,
        ST_END_CLOSE
    } t_state;

    typedef struct packed {
        logic [BSIZE_W-1:0] bin_size;
        logic [RATIO_W-1:0] norm_ratio;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic wide;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: rtl/core/binned_coverage_averager_top.sv
// Binned coverage averager: sums pileup depths into fixed-width bins and, as each bin
// closes, emits an optional span header and, for a nonzero sum and span, a value record
// (mean depth times the Q8.16 ratio, Q32.8, saturating). One input item is taken at a
// time. A position outside the window is dropped while the block stays idle. An in-range
// position that stays in the open bin waits for the 31-step divide of position by bin
// size in the shared iterative divider. A chromosome change adds the 31-step divide of
// the chromosome length and a second close. Each closed bin with a nonzero sum and span
// also passes the multiplier states, the 56-step divide by span and the result state, and
// each record may wait for the output register to be free. The last result of an item
// may wait in the output register while the next item is taken. Configuration writes are
// taken every cycle and should only be made while the block is idle; a bin size of zero
// acts as one.
`include "assert_macros.svh"

module binned_coverage_averager_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // chrom_id, position, depth, chrom_len, zero pad
    input  logic [bca_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_chrom, span, bin_start, bin_value
    output logic [bca_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // kind
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bca_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bca_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bca_pkg::*;

    logic [BSIZE_W-1:0] r_bin_size;
    logic [RATIO_W-1:0] r_norm_ratio;
    logic [POS_W-1:0]   r_range_begin;
    logic [POS_W-1:0]   r_range_end;

    t_cfg               cfg;
    logic               in_range;
    logic [CHROM_W-1:0] in_chrom;
    logic [POS_W-1:0]   in_pos;
    logic [DEPTH_W-1:0] in_depth;
    logic [POS_W-1:0]   in_clen;
    logic [CHROM_W-1:0] out_chrom;
    logic [SPAN_W-1:0]  out_span;
    logic [START_W-1:0] out_start;
    logic [VALUE_W-1:0] out_value;
    logic               rec_is_val;
    logic               rec_is_hdr;
    logic               hdr_clean;
    logic               in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_size    <= BIN_SIZE_RST;
            r_norm_ratio  <= NORM_RATIO_RST;
            r_range_begin <= RANGE_BEGIN_RST;
            r_range_end   <= RANGE_END_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BIN_SIZE:    r_bin_size    <= i_cfg_data[BSIZE_W-1:0];
                CFG_NORM_RATIO:  r_norm_ratio  <= i_cfg_data[RATIO_W-1:0];
                CFG_RANGE_BEGIN: r_range_begin <= i_cfg_data;
                CFG_RANGE_END:   r_range_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.bin_size   = (r_bin_size == '0) ? BSIZE_W'(1) : r_bin_size;
        cfg.norm_ratio = r_norm_ratio;
        in_chrom       = s_axis_tdata[15:0];
        in_pos         = s_axis_tdata[46:16];
        in_depth       = s_axis_tdata[62:47];
        in_clen        = s_axis_tdata[93:63];
        in_range       = (in_pos >= r_range_begin) && (in_pos < r_range_end);
    end

    bca_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_range  (in_range),
        .i_chrom     (in_chrom),
        .i_pos       (in_pos),
        .i_depth     (in_depth),
        .i_clen      (in_clen),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_kind  (m_axis_tuser),
        .o_out_chrom (out_chrom),
        .o_out_span  (out_span),
        .o_out_start (out_start),
        .o_out_value (out_value),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_value, out_start, out_span, out_chrom};
    assign o_cfg_ready  = 1'b1;

    assign rec_is_val = m_axis_tvalid && (m_axis_tuser == KIND_VAL);
    assign rec_is_hdr = m_axis_tvalid && (m_axis_tuser == KIND_HDR);
    assign hdr_clean  = (out_start == '0) && (out_value == '0);
    assign in_take    = s_axis_tvalid && s_axis_tready && in_range;

    `ASSERT_IMPL(a_val_no_span, rec_is_val, out_span == '0, "value record carries a span")
    `ASSERT_IMPL(a_hdr_no_value, rec_is_hdr, hdr_clean, "header record carries a value")
    `ASSERT_NEXT(a_busy_after_item, in_take, !s_axis_tready, "ready after in-range transfer")

endmodule

FILE: rtl/core/bca_div.sv
module bca_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bca_pkg::t_div_ctl         i_ctl,
    input  logic [bca_pkg::NUM_W-1:0] i_dividend,
    input  logic [bca_pkg::DEN_W-1:0] i_divisor,
    output bca_pkg::t_div_stat        o_stat,
    output logic [bca_pkg::NUM_W-1:0] o_quotient,
    output logic [bca_pkg::DEN_W-1:0] o_remainder
);
    import bca_pkg::*;

    logic [NUM_W-1:0]     r_quo, n_quo;
    logic [DEN_W-1:0]     r_rem, n_rem;
    logic [DEN_W-1:0]     r_div, n_div;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;

    always_comb begin
        trial  = {r_rem, r_quo[NUM_W-1]};
        diff   = trial - {1'b0, r_div};
        ge     = (trial >= {1'b0, r_div});
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_div  = i_divisor;
            n_rem  = '0;
            n_busy = 1'b1;
            if (i_ctl.wide) begin
                n_quo = i_dividend;
                n_cnt = DIV_CNT_W'(DIV_WIDE_STEPS);
            end else begin
                // narrow operand sits at the top so its quotient ends in the low bits
                n_quo = {i_dividend[POS_W-1:0], {(NUM_W-POS_W){1'b0}}};
                n_cnt = DIV_CNT_W'(DIV_NARROW_STEPS);
            end
        end else if (r_busy) begin
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/core/bca_core.sv
module bca_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bca_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_in_range,
    input  logic [bca_pkg::CHROM_W-1:0] i_chrom,
    input  logic [bca_pkg::POS_W-1:0]   i_pos,
    input  logic [bca_pkg::DEPTH_W-1:0] i_depth,
    input  logic [bca_pkg::POS_W-1:0]   i_clen,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_out_kind,
    output logic [bca_pkg::CHROM_W-1:0] o_out_chrom,
    output logic [bca_pkg::SPAN_W-1:0]  o_out_span,
    output logic [bca_pkg::START_W-1:0] o_out_start,
    output logic [bca_pkg::VALUE_W-1:0] o_out_value,
    output logic                        o_out_last
);
    import bca_pkg::*;

    t_state r_state, n_state;

    logic               r_chrom_valid, n_chrom_valid;
    logic [CHROM_W-1:0] r_cur_chrom, n_cur_chrom;
    logic [POS_W-1:0]   r_cur_len, n_cur_len;
    logic               r_bin_valid, n_bin_valid;
    logic [POS_W-1:0]   r_cur_bin, n_cur_bin;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic               r_fsp, n_fsp;

    logic [CHROM_W-1:0] r_in_chrom, n_in_chrom;
    logic [DEPTH_W-1:0] r_in_depth, n_in_depth;
    logic [POS_W-1:0]   r_in_clen, n_in_clen;
    logic [POS_W-1:0]   r_bin, n_bin;
    logic [SPAN_W-1:0]  r_span, n_span;
    logic               r_phase, n_phase;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [START_W-1:0] r_start, n_start;

    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic [CHROM_W-1:0] r_out_chrom, n_out_chrom;
    logic [SPAN_W-1:0]  r_out_span, n_out_span;
    logic [START_W-1:0] r_out_start, n_out_start;
    logic [VALUE_W-1:0] r_out_value, n_out_value;
    logic               r_out_last, n_out_last;

    t_div_ctl           div_ctl;
    t_div_stat          div_stat;
    logic [NUM_W-1:0]   div_dividend;
    logic [DEN_W-1:0]   div_divisor;
    logic [NUM_W-1:0]   div_quo;
    logic [DEN_W-1:0]   div_rem;

    logic [SUM_W-1:0]   mul_a;
    logic [RATIO_W-1:0] mul_b;
    logic [NUM_W-1:0]   prod;

    logic               accept;
    logic               new_chrom;
    logic               out_free;
    logic               need_hdr;
    logic               need_val;
    logic [SUM_W:0]     sum_ext;
    logic [VALUE_W-1:0] value_sat;

    bca_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // shared multiplier: sum times ratio, then bin times bin size
    always_comb begin
        if (r_state == ST_MUL_NUM) begin
            mul_a = r_sum;
            mul_b = i_cfg.norm_ratio;
        end else begin
            mul_a = {1'b0, r_cur_bin};
            mul_b = {{(RATIO_W-BSIZE_W){1'b0}}, i_cfg.bin_size};
        end
        prod = NUM_W'(mul_a) * NUM_W'(mul_b);
    end

    always_comb begin
        case (r_state)
            ST_IDLE: begin
                div_dividend = NUM_W'(i_pos);
                div_divisor  = DEN_W'(i_cfg.bin_size);
            end
            ST_DIV_POS: begin
                div_dividend = NUM_W'(r_cur_len);
                div_divisor  = DEN_W'(i_cfg.bin_size);
            end
            default: begin
                div_dividend = r_num;
                div_divisor  = {r_span, 8'h00};
            end
        endcase
    end

    always_comb begin
        accept    = i_in_valid && (r_state == ST_IDLE);
        new_chrom = !r_chrom_valid || (r_in_chrom != r_cur_chrom);
        out_free  = !r_out_valid || i_out_ready;
        need_hdr  = r_fsp || (r_span != i_cfg.bin_size);
        need_val  = (r_sum != '0) && (r_span != '0);
        sum_ext   = {1'b0, r_sum} + (SUM_W+1)'(r_in_depth);
        value_sat = (div_quo[NUM_W-1:VALUE_W] != '0) ? '1 : div_quo[VALUE_W-1:0];

        n_state       = r_state;
        n_chrom_valid = r_chrom_valid;
        n_cur_chrom   = r_cur_chrom;
        n_cur_len     = r_cur_len;
        n_bin_valid   = r_bin_valid;
        n_cur_bin     = r_cur_bin;
        n_sum         = r_sum;
        n_fsp         = r_fsp;
        n_in_chrom    = r_in_chrom;
        n_in_depth    = r_in_depth;
        n_in_clen     = r_in_clen;
        n_bin         = r_bin;
        n_span        = r_span;
        n_phase       = r_phase;
        n_num         = r_num;
        n_start       = r_start;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_kind    = r_out_kind;
        n_out_chrom   = r_out_chrom;
        n_out_span    = r_out_span;
        n_out_start   = r_out_start;
        n_out_value   = r_out_value;
        n_out_last    = r_out_last;
        div_ctl.start = 1'b0;
        div_ctl.wide  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept && i_in_range) begin
                    n_in_chrom    = i_chrom;
                    n_in_depth    = i_depth;
                    n_in_clen     = i_clen;
                    div_ctl.start = 1'b1;
                    n_state       = ST_DIV_POS;
                end
            end
            ST_DIV_POS: begin
                if (div_stat.done) begin
                    n_bin = div_quo[POS_W-1:0];
                    if (new_chrom && r_chrom_valid) begin
                        div_ctl.start = 1'b1;
                        n_state       = ST_DIV_LEN;
                    end else if (new_chrom) begin
                        n_chrom_valid = 1'b1;
                        n_cur_chrom   = r_in_chrom;
                        n_cur_len     = r_in_clen;
                        n_fsp         = 1'b1;
                        n_bin_valid   = 1'b0;
                        n_state       = ST_BIN;
                    end else begin
                        n_state = ST_BIN;
                    end
                end
            end
            ST_DIV_LEN: begin
                if (div_stat.done) begin
                    // chromosome end: short span only if the open bin is the tail bin
                    if (div_quo[POS_W-1:0] == r_cur_bin) begin
                        n_span = div_rem[SPAN_W-1:0];
                    end else begin
                        n_span = i_cfg.bin_size;
                    end
                    n_phase = 1'b0;
                    n_state = ST_HDR;
                end
            end
            ST_BIN: begin
                if (!r_bin_valid || (r_bin != r_cur_bin)) begin
                    n_span  = i_cfg.bin_size;
                    n_phase = 1'b1;
                    n_state = ST_HDR;
                end else begin
                    n_sum   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            ST_HDR: begin
                if (!need_hdr) begin
                    n_state = need_val ? ST_MUL_NUM : ST_END_CLOSE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_HDR;
                    n_out_chrom = r_cur_chrom;
                    n_out_span  = r_span;
                    n_out_start = '0;
                    n_out_value = '0;
                    n_out_last  = r_phase && !need_val;
                    n_state     = need_val ? ST_MUL_NUM : ST_END_CLOSE;
                end
            end
            ST_MUL_NUM: begin
                n_num   = prod;
                n_state = ST_MUL_START;
            end
            ST_MUL_START: begin
                n_start       = prod[START_W-1:0] + 32'd1;
                div_ctl.start = 1'b1;
                div_ctl.wide  = 1'b1;
                n_state       = ST_DIV_VAL;
            end
            ST_DIV_VAL: begin
                if (div_stat.done) begin
                    n_state = ST_VAL;
                end
            end
            ST_VAL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_VAL;
                    n_out_chrom = r_cur_chrom;
                    n_out_span  = '0;
                    n_out_start = r_start;
                    n_out_value = value_sat;
                    n_out_last  = r_phase;
                    n_state     = ST_END_CLOSE;
                end
            end
            ST_END_CLOSE: begin
                if (!r_phase) begin
                    n_sum         = '0;
                    n_chrom_valid = 1'b1;
                    n_cur_chrom   = r_in_chrom;
                    n_cur_len     = r_in_clen;
                    n_fsp         = 1'b1;
                    n_bin_valid   = 1'b0;
                    n_state       = ST_BIN;
                end else begin
                    n_sum       = SUM_W'(r_in_depth);
                    n_fsp       = 1'b0;
                    n_cur_bin   = r_bin;
                    n_bin_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_chrom_valid <= 1'b0;
            r_cur_chrom   <= '0;
            r_cur_len     <= '0;
            r_bin_valid   <= 1'b0;
            r_cur_bin     <= '0;
            r_sum         <= '0;
            r_fsp         <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_chrom_valid <= n_chrom_valid;
            r_cur_chrom   <= n_cur_chrom;
            r_cur_len     <= n_cur_len;
            r_bin_valid   <= n_bin_valid;
            r_cur_bin     <= n_cur_bin;
            r_sum         <= n_sum;
            r_fsp         <= n_fsp;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_chrom  <= n_in_chrom;
        r_in_depth  <= n_in_depth;
        r_in_clen   <= n_in_clen;
        r_bin       <= n_bin;
        r_span      <= n_span;
        r_phase     <= n_phase;
        r_num       <= n_num;
        r_start     <= n_start;
        r_out_kind  <= n_out_kind;
        r_out_chrom <= n_out_chrom;
        r_out_span  <= n_out_span;
        r_out_start <= n_out_start;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_chrom = r_out_chrom;
    assign o_out_span  = r_out_span;
    assign o_out_start = r_out_start;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

FILE: tb/tb_binned_coverage_averager_top.sv
module tb_binned_coverage_averager_top;
    import bca_pkg::*;

    localparam int unsigned          IDLE_PCT        = 24;
    localparam int unsigned          SETTLE_CYCLES   = 400;
    localparam int unsigned          STALL_LIMIT     = 4000;
    localparam int unsigned          REPORT_LIMIT    = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH_REG = 8'd9;
    localparam logic [POS_W-1:0]     POS_MAX         = 31'h7fffffff;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   position;
        logic [DEPTH_W-1:0] depth;
        logic [POS_W-1:0]   chrom_len;
    } t_pileup;

    typedef struct packed {
        logic               kind;
        logic [CHROM_W-1:0] chrom;
        logic [SPAN_W-1:0]  span;
        logic [START_W-1:0] bin_start;
        logic [VALUE_W-1:0] bin_value;
        logic               last;
    } t_bin_record;

    class coverage_scoreboard;
        logic [BSIZE_W-1:0] bin_size      = BIN_SIZE_RST;
        logic [RATIO_W-1:0] norm_ratio    = NORM_RATIO_RST;
        logic [POS_W-1:0]   range_begin   = RANGE_BEGIN_RST;
        logic [POS_W-1:0]   range_end     = RANGE_END_RST;
        logic               chrom_open    = 1'b0;
        logic [CHROM_W-1:0] chrom_now     = '0;
        logic [POS_W-1:0]   chrom_len_now = '0;
        logic               bin_open      = 1'b0;
        logic [POS_W-1:0]   slot_now      = '0;
        logic [SUM_W-1:0]   depth_sum     = '0;
        logic               first_span    = 1'b1;
        t_bin_record        awaited[$];
        t_bin_record        fresh[$];
        int unsigned        errors        = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BIN_SIZE:    bin_size    = data[BSIZE_W-1:0];
                CFG_NORM_RATIO:  norm_ratio  = data[RATIO_W-1:0];
                CFG_RANGE_BEGIN: range_begin = data[POS_W-1:0];
                CFG_RANGE_END:   range_end   = data[POS_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [BSIZE_W-1:0] eff_size();
            return (bin_size == '0) ? 16'd1 : bin_size;
        endfunction

        function void emit(logic kind, logic [CHROM_W-1:0] chrom, logic [SPAN_W-1:0] span,
                           logic [START_W-1:0] start, logic [VALUE_W-1:0] value);
            t_bin_record rec;
            rec.kind      = kind;
            rec.chrom     = chrom;
            rec.span      = span;
            rec.bin_start = start;
            rec.bin_value = value;
            rec.last      = 1'b0;
            fresh.push_back(rec);
        endfunction

        function void shut_bin(logic [CHROM_W-1:0] chrom, logic [SPAN_W-1:0] span);
            logic [BSIZE_W-1:0] bs;
            logic [63:0]        quot;
            logic [63:0]        first_pos;
            bs = eff_size();
            if (first_span || span != bs)
                emit(KIND_HDR, chrom, span, '0, '0);
            first_span = 1'b0;
            if (depth_sum != '0 && span != '0) begin
                quot = (64'(depth_sum) * 64'(norm_ratio)) / (64'(span) * 64'd256);
                if (quot > 64'hff_ffff_ffff)
                    quot = 64'hff_ffff_ffff;
                first_pos = 64'(slot_now) * 64'(bs) + 64'd1;
                emit(KIND_VAL, chrom, '0, first_pos[START_W-1:0], quot[VALUE_W-1:0]);
            end
            depth_sum = '0;
        endfunction

        function void note_pileup(t_pileup p);
            logic [BSIZE_W-1:0] bs;
            logic [SPAN_W-1:0]  span;
            logic [POS_W-1:0]   slot;
            logic [SUM_W:0]     total;
            bs = eff_size();
            fresh.delete();
            if (p.position < range_begin || p.position >= range_end)
                return;
            if (!chrom_open || p.chrom != chrom_now) begin
                if (chrom_open) begin
                    span = bs;
                    if (chrom_len_now / bs == slot_now)
                        span = SPAN_W'(chrom_len_now % bs);
                    shut_bin(chrom_now, span);
                end
                chrom_open    = 1'b1;
                chrom_now     = p.chrom;
                chrom_len_now = p.chrom_len;
                first_span    = 1'b1;
                bin_open      = 1'b0;
            end
            slot = p.position / bs;
            if (!bin_open || slot != slot_now) begin
                shut_bin(chrom_now, bs);
                slot_now = slot;
                bin_open = 1'b1;
            end
            total     = {1'b0, depth_sum} + p.depth;
            depth_sum = total[SUM_W] ? '1 : total[SUM_W-1:0];
            if (fresh.size() != 0)
                fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[i])
                awaited.push_back(fresh[i]);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_record(t_bin_record got);
            t_bin_record want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected record, expected none, actual %p", $time, got);
                return;
            end
            want = awaited.pop_front();
            compare("kind", 64'(want.kind), 64'(got.kind));
            compare("out_chrom", 64'(want.chrom), 64'(got.chrom));
            compare("span", 64'(want.span), 64'(got.span));
            compare("bin_start", 64'(want.bin_start), 64'(got.bin_start));
            compare("bin_value", 64'(want.bin_value), 64'(got.bin_value));
            compare("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    coverage_scoreboard board = new;
    t_bin_record        seen_rec;
    bit                 steady = 1'b0;
    int unsigned        quiet_cycles = 0;

    binned_coverage_averager_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_rec.kind      = m_axis_tuser;
            seen_rec.chrom     = m_axis_tdata[15:0];
            seen_rec.span      = m_axis_tdata[31:16];
            seen_rec.bin_start = m_axis_tdata[63:32];
            seen_rec.bin_value = m_axis_tdata[103:64];
            seen_rec.last      = m_axis_tlast;
            board.check_record(seen_rec);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic configure(logic [BSIZE_W-1:0] bs, logic [RATIO_W-1:0] ratio,
                             logic [POS_W-1:0] lo, logic [POS_W-1:0] hi, bit poke_unused);
        write_reg(CFG_BIN_SIZE, CFG_DATA_W'(bs));
        write_reg(CFG_NORM_RATIO, CFG_DATA_W'(ratio));
        write_reg(CFG_RANGE_BEGIN, lo);
        write_reg(CFG_RANGE_END, hi);
        if (poke_unused)
            write_reg(CFG_NO_SUCH_REG, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic [CHROM_W-1:0] chrom, logic [POS_W-1:0] position,
                             logic [DEPTH_W-1:0] depth, logic [POS_W-1:0] chrom_len);
        t_pileup p;
        p.chrom     = chrom;
        p.position  = position;
        p.depth     = depth;
        p.chrom_len = chrom_len;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({chrom_len, depth, position, chrom});
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_pileup(p);
        @(negedge i_clk);
    endtask

    // waits out the last result and any bin still being worked on
    task automatic settle();
        while (board.awaited.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sorted runs per chromosome with random content, salted with noise transfers
    task automatic random_stream(int unsigned want, logic [BSIZE_W-1:0] bs_cfg,
                                 logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
        int unsigned        taken;
        int unsigned        tries;
        int unsigned        per_chrom;
        int unsigned        bs;
        longint unsigned    pos;
        longint unsigned    len;
        longint unsigned    width;
        longint unsigned    near;
        logic [CHROM_W-1:0] chrom;
        logic [DEPTH_W-1:0] depth;
        logic [POS_W-1:0]   noise_pos;
        bs    = (bs_cfg == '0) ? 32'd1 : 32'(bs_cfg);
        width = (hi > lo) ? longint'(hi) - longint'(lo) : 1;
        near  = (width > 4096) ? 4096 : width - 1;
        taken = 0;
        tries = 0;
        chrom = 16'($urandom);
        while (taken < want && tries < want * 6) begin
            tries++;
            if ($urandom_range(4) != 0)
                chrom = 16'($urandom);
            if ($urandom_range(4) == 0)
                pos = longint'(lo) + ({$urandom, $urandom} % width);
            else
                pos = longint'(lo) + $urandom_range(32'(near), 0);
            len = pos + $urandom_range(bs * 4, 1);
            if (len > POS_MAX)
                len = POS_MAX;
            if ($urandom_range(7) == 0)
                len = $urandom & POS_MAX;
            per_chrom = $urandom_range(24, 2);
            for (int unsigned k = 0; k < per_chrom && taken < want; k++) begin
                tries++;
                if ($urandom_range(9) == 0) begin
                    noise_pos = 31'($urandom);
                    send_item(16'($urandom), noise_pos, 16'($urandom), 31'($urandom));
                    if (noise_pos >= lo && noise_pos < hi)
                        taken++;
                end else begin
                    if (pos > POS_MAX)
                        break;
                    case ($urandom_range(3))
                        0:       depth = '0;
                        1:       depth = '1;
                        default: depth = 16'($urandom);
                    endcase
                    send_item(chrom, pos[POS_W-1:0], depth, len[POS_W-1:0]);
                    if (pos >= lo && pos < hi)
                        taken++;
                    if ($urandom_range(5) == 0)
                        pos += $urandom_range(bs * 3, 0);
                    else
                        pos += $urandom_range((bs + 3) / 4, 0);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic run_phase(logic [BSIZE_W-1:0] bs, logic [RATIO_W-1:0] ratio,
                             logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                             int unsigned want, bit poke_unused);
        configure(bs, ratio, lo, hi, poke_unused);
        random_stream(want, bs, lo, hi);
        settle();
    endtask

    initial begin
        logic [POS_W-1:0] lo_pick;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        configure(BIN_SIZE_RST, NORM_RATIO_RST, RANGE_BEGIN_RST, RANGE_END_RST, 1'b0);

        // first chromosome, bin changes, window edge, zero sums
        send_item(16'd0, 31'd0, 16'd0, 31'd1);
        send_item(16'd0, 31'd10, 16'hffff, 31'd1);
        send_item(16'd0, 31'd49, 16'd1, 31'd1);
        send_item(16'd0, 31'd50, 16'd7, 31'd1);
        send_item(16'd0, POS_MAX, 16'd5, 31'd1);
        send_item(16'd0, 31'd120, 16'd0, 31'd1);
        send_item(16'd0, 31'd130, 16'd0, 31'd1);
        // chromosome changes, short span at chromosome end
        send_item(16'd1, 31'd0, 16'd3, 31'd100);
        send_item(16'd1, 31'd99, 16'd4, 31'd100);
        send_item(16'd2, 31'd5, 16'd9, 31'd100);
        send_item(16'd3, 31'd110, 16'hffff, 31'd120);
        send_item(16'd3, 31'd119, 16'hffff, 31'd120);
        send_item(16'hffff, 31'd3, 16'd1, POS_MAX);
        send_item(16'hffff, 31'h7ffffffe, 16'hffff, POS_MAX);
        // zero span at chromosome end, zero chromosome length
        send_item(16'd4, 31'd100, 16'd8, 31'd100);
        send_item(16'd5, 31'd0, 16'd1, 31'd0);
        send_item(16'd5, 31'd0, 16'd0, 31'd0);
        send_item(16'd6, 31'd1, 16'd1, 31'd1);
        send_item(16'd6, 31'd1, 16'd2, 31'd1);
        send_item(16'd6, 31'd0, 16'd2, 31'd1);
        s_axis_tvalid <= 1'b0;
        settle();

        // zero bin size acts as one
        run_phase(16'd0, 24'hffffff, 31'd0, POS_MAX, 25, 1'b0);
        steady = 1'b1;
        run_phase(16'hffff, 24'd1, 31'd1000, 31'h7fff0000, 25, 1'b0);
        steady = 1'b0;
        lo_pick = 31'($urandom_range(32'h4000_0000, 0));
        run_phase(16'($urandom_range(200, 2)), 24'($urandom), lo_pick,
                  lo_pick + 31'($urandom_range(32'h0010_0000, 1)), 30, 1'b0);
        run_phase(16'd3, 24'd65536, 31'h7ffffff0, POS_MAX, 12, 1'b0);
        // empty window, plus a write to a register index that does not exist
        run_phase(16'd1, 24'd0, 31'd0, 31'd0, 4, 1'b1);
        run_phase(16'd17, 24'd300000, 31'd0, 31'd5000, 30, 1'b0);
        run_phase(16'($urandom_range(1000, 1)), 24'($urandom), 31'd0, POS_MAX, 25, 1'b0);

        // saturated value: a one-position span at chromosome end holding a large sum
        configure(16'd400, 24'hffffff, 31'd0, POS_MAX, 1'b0);
        for (int unsigned i = 0; i < 260; i++)
            send_item(16'd7, 31'(400 + i), 16'hffff, 31'd401);
        send_item(16'd8, 31'd0, 16'd1, 31'd1);
        s_axis_tvalid <= 1'b0;
        settle();

        if (board.errors == 0 && board.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/bca_pkg.sv
rtl/core/bca_div.sv
rtl/core/bca_core.sv
rtl/core/binned_coverage_averager_top.sv
tb/tb_binned_coverage_averager_top.sv
